// File: sv/sdmi_pkg.sv
package sdmi_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    localparam int RMAX   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int X_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int Y_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XY_W   = (X_W > Y_W) ? X_W : Y_W;
    localparam int WU_W   = $clog2(MAX_WIDTH + 1);
    localparam int HU_W   = $clog2(MAX_HEIGHT + 1);
    localparam int R_W    = $clog2(RMAX + 1);
    localparam int S_W    = R_W + 2;
    localparam int SUM_W  = 2 * XY_W + 1;

    localparam int CMD_W     = 2;
    localparam int COORD_W   = 9;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int DIST_W    = 19;
    localparam int COUNT_W   = 19;
    localparam int CMP_W     = (SUM_W > DIST_W) ? SUM_W : DIST_W;

    localparam logic [DIST_W-1:0]  NO_OBSTACLE  = 19'h7FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 19'h7FFFF;
    localparam logic [CFG_W-1:0]   WIDTH_RESET  = 10'd512;
    localparam logic [CFG_W-1:0]   HEIGHT_RESET = 10'd512;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        SEG_TOP    = 2'd0,
        SEG_BOTTOM = 2'd1,
        SEG_LEFT   = 2'd2,
        SEG_RIGHT  = 2'd3
    } seg_t;

    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_READ = 2'd1,
        RES_FULL = 2'd2
    } res_sel_t;

    typedef enum logic [3:0] {
        ST_INIT_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_QUERY_RD,
        ST_QUERY_WAIT,
        ST_CENTER,
        ST_SEG_INIT,
        ST_SCAN,
        ST_DRAIN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic     load;
        logic     decode;
        logic     clr_step;
        logic     count_clear;
        logic     center_write;
        logic     query_read;
        logic     ring_first;
        logic     ring_next;
        logic     seg_init;
        logic     seg_next;
        logic     scan_step;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } sdmi_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             outside;
        logic             clr_last;
        logic             seg_ok;
        logic             seg_last;
        logic             scan_last;
        logic             pipe_empty;
        logic             lowered;
        logic             ring_last;
    } sdmi_stat_t;

endpackage

// File: sv/sdmi_ifs.sv
interface sdmi_item_if
    import sdmi_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;

    modport source (output valid, output cmd, output x, output y, input ready);
    modport sink (input valid, input cmd, input x, input y, output ready);
endinterface

interface sdmi_result_if
    import sdmi_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [DIST_W-1:0]  distance;
    logic [COUNT_W-1:0] obstacle_count;
    logic               status;

    modport source (output valid, output distance, output obstacle_count, output status,
                    input ready);
    modport sink (input valid, input distance, input obstacle_count, input status,
                  output ready);
endinterface

interface sdmi_cfg_if
    import sdmi_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/squared_distance_map_insert_core.sv
// Channel   Direction  Contents
// items     in         cmd, x, y
// results   out        distance, obstacle_count, status
// cfg       in         index, data (0 image width, 1 image height)
//
// After reset the whole map is filled with NO_OBSTACLE before the first item is taken.
// An add writes its point, then walks rings outward: per ring it scans each in-image ring side
// and drains the read, compare and write pipeline, stopping when a ring lowers no pixel.
// One item is processed at a time; a finished result waits in the output register
// while the next item is taken, and a stalled result transfer holds back the following one.
module squared_distance_map_insert_core
    import sdmi_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sdmi_item_if.sink     items,
    sdmi_result_if.source results,
    sdmi_cfg_if.sink      cfg
);

    sdmi_ctrl_t ctrl;
    sdmi_stat_t stat;

    assign cfg.ready = 1'b1;

    sdmi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    sdmi_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .stat           (stat),
        .in_cmd         (items.cmd),
        .in_x           (items.x),
        .in_y           (items.y),
        .cfg_write      (cfg.valid && cfg.ready),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .distance       (results.distance),
        .obstacle_count (results.obstacle_count),
        .status         (results.status)
    );

    a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |=> results.valid)
        else $error("result not presented after load");

    a_accept_then_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready) |=> ctrl.decode)
        else $error("accepted item not decoded");

    a_rejected_has_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.status) |-> (results.distance == '0))
        else $error("rejected item reports a distance");

    a_single_store_use: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.clr_step, ctrl.center_write, ctrl.scan_step, ctrl.query_read}))
        else $error("conflicting store commands");

endmodule

// File: sv/sdmi_ctrl.sv
module sdmi_ctrl
    import sdmi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  sdmi_stat_t stat,
    output sdmi_ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.cmd == CMD_CLEAR)
                begin
                    state_next = ST_CLEAR;
                end
                else if (stat.outside)
                begin
                    state_next = ST_RESP;
                end
                else if (stat.cmd == CMD_ADD)
                begin
                    state_next = ST_CENTER;
                end
                else
                begin
                    state_next = ST_QUERY_RD;
                end
            end
            ST_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_QUERY_RD:   state_next = ST_QUERY_WAIT;
            ST_QUERY_WAIT: state_next = ST_RESP;
            ST_CENTER:     state_next = ST_SEG_INIT;
            ST_SEG_INIT:
            begin
                if (stat.seg_ok)
                begin
                    state_next = ST_SCAN;
                end
                else if (stat.seg_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = stat.seg_last ? ST_DRAIN : ST_SEG_INIT;
                end
            end
            ST_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    state_next = (stat.lowered && !stat.ring_last) ? ST_SEG_INIT : ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT_CLEAR;
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_INIT_CLEAR:
            begin
                ctrl.clr_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
            end
            ST_DECODE:
            begin
                ctrl.decode = 1'b1;
                if (stat.cmd != CMD_CLEAR && stat.outside)
                begin
                    ctrl.res_load = 1'b1;
                    ctrl.res_sel  = RES_ZERO;
                end
            end
            ST_CLEAR:
            begin
                ctrl.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    ctrl.count_clear = 1'b1;
                    ctrl.res_load    = 1'b1;
                    ctrl.res_sel     = RES_FULL;
                end
            end
            ST_QUERY_RD:
            begin
                ctrl.query_read = 1'b1;
            end
            ST_QUERY_WAIT:
            begin
                ctrl.res_load = 1'b1;
                ctrl.res_sel  = RES_READ;
            end
            ST_CENTER:
            begin
                ctrl.center_write = 1'b1;
                ctrl.ring_first   = 1'b1;
                ctrl.res_load     = 1'b1;
                ctrl.res_sel      = RES_ZERO;
            end
            ST_SEG_INIT:
            begin
                if (stat.seg_ok)
                begin
                    ctrl.seg_init = 1'b1;
                end
                else if (!stat.seg_last)
                begin
                    ctrl.seg_next = 1'b1;
                end
            end
            ST_SCAN:
            begin
                ctrl.scan_step = 1'b1;
                ctrl.seg_next  = stat.scan_last && !stat.seg_last;
            end
            ST_DRAIN:
            begin
                ctrl.ring_next = stat.pipe_empty && stat.lowered && !stat.ring_last;
            end
            ST_RESP:
            begin
                ctrl.out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_comb
    begin
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: sv/sdmi_datapath.sv
module sdmi_datapath
    import sdmi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sdmi_ctrl_t           ctrl,
    output sdmi_stat_t           stat,
    input  logic [CMD_W-1:0]     in_cmd,
    input  logic [COORD_W-1:0]   in_x,
    input  logic [COORD_W-1:0]   in_y,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic [DIST_W-1:0]    distance,
    output logic [COUNT_W-1:0]   obstacle_count,
    output logic                 status
);

    localparam logic signed [S_W-1:0] S_ZERO = '0;
    localparam logic signed [S_W-1:0] S_ONE  = 1;

    logic [DIST_W-1:0] store_mem [DEPTH];

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [ADDR_W-1:0]  center_addr_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               status_reg;
    logic [DIST_W-1:0]  res_dist_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_status_reg;

    logic [R_W-1:0]         r_reg;
    seg_t                   seg_reg;
    logic signed [S_W-1:0]  i_reg;
    logic                   lowered_reg;

    logic                   a_valid_reg;
    logic [X_W-1:0]         a_u_reg;
    logic [Y_W-1:0]         a_v_reg;
    logic                   b_valid_reg;
    logic [ADDR_W-1:0]      b_addr_reg;
    logic [DIST_W-1:0]      b_d_reg;
    logic                   c_valid_reg;
    logic [ADDR_W-1:0]      c_addr_reg;
    logic [DIST_W-1:0]      c_d_reg;
    logic [DIST_W-1:0]      rd_data_reg;

    logic [WU_W-1:0]        w_use;
    logic [HU_W-1:0]        h_use;
    logic [X_W-1:0]         cx;
    logic [Y_W-1:0]         cy;
    logic                   outside;
    logic [Y_W+WU_W-1:0]    center_prod;

    logic signed [S_W-1:0]  sx;
    logic signed [S_W-1:0]  sy;
    logic signed [S_W-1:0]  sr;
    logic signed [S_W-1:0]  sw;
    logic signed [S_W-1:0]  sh;
    logic signed [S_W-1:0]  top_v;
    logic signed [S_W-1:0]  bot_v;
    logic signed [S_W-1:0]  left_u;
    logic signed [S_W-1:0]  right_u;
    logic signed [S_W-1:0]  row_lo;
    logic signed [S_W-1:0]  row_hi;
    logic signed [S_W-1:0]  col_lo;
    logic signed [S_W-1:0]  col_hi;
    logic signed [S_W-1:0]  seg_lo;
    logic signed [S_W-1:0]  seg_hi;
    logic signed [S_W-1:0]  pix_u;
    logic signed [S_W-1:0]  pix_v;
    logic                   seg_ok;

    logic [X_W-1:0]         dx;
    logic [Y_W-1:0]         dy;
    logic [SUM_W-1:0]       dsum;
    logic [DIST_W-1:0]      d_sat;
    logic [Y_W+WU_W-1:0]    pix_prod;
    logic [ADDR_W-1:0]      pix_addr;

    logic                   lower;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [DIST_W-1:0]      wr_data;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;

    assign w_use = (int'(width_reg) > MAX_WIDTH) ? WU_W'(MAX_WIDTH) : WU_W'(width_reg);
    assign h_use = (int'(height_reg) > MAX_HEIGHT) ? HU_W'(MAX_HEIGHT) : HU_W'(height_reg);
    assign cx    = X_W'(x_reg);
    assign cy    = Y_W'(y_reg);
    assign outside = (int'(x_reg) >= int'(w_use)) || (int'(y_reg) >= int'(h_use));
    assign center_prod = (Y_W+WU_W)'(cy) * (Y_W+WU_W)'(w_use);

    // Ring geometry for the current radius, clipped to the image.
    assign sx      = $signed(S_W'(cx));
    assign sy      = $signed(S_W'(cy));
    assign sr      = $signed(S_W'(r_reg));
    assign sw      = $signed(S_W'(w_use));
    assign sh      = $signed(S_W'(h_use));
    assign top_v   = sy - sr;
    assign bot_v   = sy + sr;
    assign left_u  = sx - sr;
    assign right_u = sx + sr;
    assign row_lo  = (left_u < S_ZERO) ? S_ZERO : left_u;
    assign row_hi  = (right_u > sw - S_ONE) ? sw - S_ONE : right_u;
    assign col_lo  = (top_v + S_ONE < S_ZERO) ? S_ZERO : top_v + S_ONE;
    assign col_hi  = (bot_v - S_ONE > sh - S_ONE) ? sh - S_ONE : bot_v - S_ONE;

    always_comb
    begin
        case (seg_reg)
            SEG_TOP:
            begin
                seg_ok = top_v >= S_ZERO;
                seg_lo = row_lo;
                seg_hi = row_hi;
                pix_u  = i_reg;
                pix_v  = top_v;
            end
            SEG_BOTTOM:
            begin
                seg_ok = bot_v < sh;
                seg_lo = row_lo;
                seg_hi = row_hi;
                pix_u  = i_reg;
                pix_v  = bot_v;
            end
            SEG_LEFT:
            begin
                seg_ok = (left_u >= S_ZERO) && (col_lo <= col_hi);
                seg_lo = col_lo;
                seg_hi = col_hi;
                pix_u  = left_u;
                pix_v  = i_reg;
            end
            SEG_RIGHT:
            begin
                seg_ok = (right_u < sw) && (col_lo <= col_hi);
                seg_lo = col_lo;
                seg_hi = col_hi;
                pix_u  = right_u;
                pix_v  = i_reg;
            end
            default:
            begin
                seg_ok = 1'b0;
                seg_lo = S_ZERO;
                seg_hi = S_ZERO;
                pix_u  = S_ZERO;
                pix_v  = S_ZERO;
            end
        endcase
    end

    // Pixel pipeline: address and squared distance, then read, then compare and write.
    assign dx       = (a_u_reg > cx) ? a_u_reg - cx : cx - a_u_reg;
    assign dy       = (a_v_reg > cy) ? a_v_reg - cy : cy - a_v_reg;
    assign dsum     = SUM_W'(dx) * SUM_W'(dx) + SUM_W'(dy) * SUM_W'(dy);
    assign d_sat    = (CMP_W'(dsum) > CMP_W'(NO_OBSTACLE)) ? NO_OBSTACLE : DIST_W'(dsum);
    assign pix_prod = (Y_W+WU_W)'(a_v_reg) * (Y_W+WU_W)'(w_use);
    assign pix_addr = ADDR_W'(pix_prod) + ADDR_W'(a_u_reg);

    assign lower = c_valid_reg && (rd_data_reg > c_d_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = c_addr_reg;
        wr_data = c_d_reg;
        if (ctrl.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = NO_OBSTACLE;
        end
        else if (ctrl.center_write)
        begin
            wr_en   = 1'b1;
            wr_addr = center_addr_reg;
            wr_data = '0;
        end
        else if (lower)
        begin
            wr_en = 1'b1;
        end
    end

    assign rd_en   = ctrl.query_read || b_valid_reg;
    assign rd_addr = ctrl.query_read ? center_addr_reg : b_addr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            clr_addr_reg <= '0;
            count_reg    <= '0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            lowered_reg  <= 1'b0;
            r_reg        <= '0;
            seg_reg      <= SEG_TOP;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                begin
                    width_reg <= cfg_data;
                end
                else if (cfg_index == REG_IMAGE_HEIGHT)
                begin
                    height_reg <= cfg_data;
                end
            end

            if (ctrl.clr_step)
            begin
                clr_addr_reg <= stat.clr_last ? '0 : clr_addr_reg + ADDR_W'(1);
            end

            if (ctrl.count_clear)
            begin
                count_reg <= '0;
            end
            else if (ctrl.center_write && count_reg < COUNT_MAX)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end

            if (ctrl.ring_first)
            begin
                r_reg   <= R_W'(1);
                seg_reg <= SEG_TOP;
            end
            else if (ctrl.ring_next)
            begin
                r_reg   <= r_reg + R_W'(1);
                seg_reg <= SEG_TOP;
            end
            else if (ctrl.seg_next)
            begin
                seg_reg <= seg_t'(seg_reg + 2'd1);
            end

            if (ctrl.ring_first || ctrl.ring_next)
            begin
                lowered_reg <= 1'b0;
            end
            else if (lower)
            begin
                lowered_reg <= 1'b1;
            end

            a_valid_reg <= ctrl.scan_step;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= in_cmd;
            x_reg   <= in_x;
            y_reg   <= in_y;
        end
        if (ctrl.decode)
        begin
            status_reg      <= outside && (cmd_reg != CMD_CLEAR);
            center_addr_reg <= ADDR_W'(center_prod) + ADDR_W'(cx);
        end
        if (ctrl.seg_init)
        begin
            i_reg <= seg_lo;
        end
        else if (ctrl.scan_step)
        begin
            i_reg <= i_reg + S_ONE;
        end
        if (ctrl.scan_step)
        begin
            a_u_reg <= X_W'(pix_u);
            a_v_reg <= Y_W'(pix_v);
        end
        b_addr_reg <= pix_addr;
        b_d_reg    <= d_sat;
        c_addr_reg <= b_addr_reg;
        c_d_reg    <= b_d_reg;
        if (ctrl.res_load)
        begin
            case (ctrl.res_sel)
                RES_ZERO: res_dist_reg <= '0;
                RES_READ: res_dist_reg <= rd_data_reg;
                RES_FULL: res_dist_reg <= NO_OBSTACLE;
                default:  res_dist_reg <= '0;
            endcase
        end
        if (ctrl.out_load)
        begin
            out_dist_reg   <= res_dist_reg;
            out_count_reg  <= count_reg;
            out_status_reg <= status_reg;
        end
    end

    assign stat.cmd        = cmd_reg;
    assign stat.outside    = outside;
    assign stat.clr_last   = clr_addr_reg == ADDR_W'(DEPTH - 1);
    assign stat.seg_ok     = seg_ok;
    assign stat.seg_last   = seg_reg == SEG_RIGHT;
    assign stat.scan_last  = i_reg == seg_hi;
    assign stat.pipe_empty = !a_valid_reg && !b_valid_reg && !c_valid_reg;
    assign stat.lowered    = lowered_reg;
    assign stat.ring_last  = r_reg == R_W'(RMAX);

    assign distance       = out_dist_reg;
    assign obstacle_count = out_count_reg;
    assign status         = out_status_reg;

endmodule

// File: dv/squared_distance_map_insert_core_tb.sv
`timescale 1ns / 1ps

module squared_distance_map_insert_core_tb;
    import sdmi_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int ADD_AREA_LIMIT = 4096;
    localparam longint TIMEOUT_NS = 64'd320_000_000;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [COUNT_W-1:0] obstacle_count;
        logic               status;
    } map_result_t;

    logic clk;
    logic rst_n;

    sdmi_item_if   items_if ();
    sdmi_result_if results_if ();
    sdmi_cfg_if    cfg_if ();

    squared_distance_map_insert_core dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    logic [DIST_W-1:0]  exp_map [DEPTH];
    logic [COUNT_W-1:0] obstacles;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;

    map_result_t pending_map_results [$];
    map_result_t oldest_result;
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void clear_map();
        foreach (exp_map[i])
        begin
            exp_map[i] = NO_OBSTACLE;
        end
        obstacles = '0;
    endfunction

    function automatic int width_in_use();
        return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    endfunction

    function automatic int height_in_use();
        return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    endfunction

    function automatic bit lower_pixel(int u, int v, int cx, int cy, int w);
        int dx;
        int dy;
        int d;
        int idx;
        dx = (u > cx) ? u - cx : cx - u;
        dy = (v > cy) ? v - cy : cy - v;
        d = dx * dx + dy * dy;
        if (d > NO_OBSTACLE)
        begin
            d = NO_OBSTACLE;
        end
        idx = u + v * w;
        if (idx >= DEPTH)
        begin
            return 1'b0;
        end
        if (exp_map[idx] > d)
        begin
            exp_map[idx] = d[DIST_W-1:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic map_result_t predict_map_step(logic [CMD_W-1:0] c, int cx, int cy);
        int          w;
        int          h;
        int          idx;
        int          r;
        int          lo;
        int          hi;
        int          k;
        int          i;
        int          v;
        int          u;
        bit          lowered;
        map_result_t res;
        w = width_in_use();
        h = height_in_use();
        res = '0;
        if (c == CMD_CLEAR)
        begin
            clear_map();
            res.distance = NO_OBSTACLE;
        end
        else if (cx >= w || cy >= h)
        begin
            res.status = 1'b1;
        end
        else
        begin
            idx = cx + cy * w;
            if (idx >= DEPTH)
            begin
                idx = 0;
            end
            if (c == CMD_ADD)
            begin
                exp_map[idx] = '0;
                if (obstacles < COUNT_MAX)
                begin
                    obstacles = obstacles + COUNT_W'(1);
                end
                for (r = 1; r <= RMAX; r++)
                begin
                    lowered = 1'b0;
                    lo = (cx - r < 0) ? 0 : cx - r;
                    hi = (cx + r > w - 1) ? w - 1 : cx + r;
                    for (k = -1; k <= 1; k += 2)
                    begin
                        v = cy + k * r;
                        if (v >= 0 && v < h)
                        begin
                            for (i = lo; i <= hi; i++)
                            begin
                                if (lower_pixel(i, v, cx, cy, w))
                                begin
                                    lowered = 1'b1;
                                end
                            end
                        end
                    end
                    lo = (cy - r + 1 < 0) ? 0 : cy - r + 1;
                    hi = (cy + r - 1 > h - 1) ? h - 1 : cy + r - 1;
                    for (k = -1; k <= 1; k += 2)
                    begin
                        u = cx + k * r;
                        if (u >= 0 && u < w)
                        begin
                            for (i = lo; i <= hi; i++)
                            begin
                                if (lower_pixel(u, i, cx, cy, w))
                                begin
                                    lowered = 1'b1;
                                end
                            end
                        end
                    end
                    if (!lowered)
                    begin
                        break;
                    end
                end
            end
            res.distance = exp_map[idx];
        end
        res.obstacle_count = obstacles;
        return res;
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] c, input logic [COORD_W-1:0] px,
                             input logic [COORD_W-1:0] py);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            items_if.valid <= 1'b0;
            @(posedge clk);
        end
        items_if.valid <= 1'b1;
        items_if.cmd   <= c;
        items_if.x     <= px;
        items_if.y     <= py;
        do
        begin
            @(posedge clk);
        end
        while (!items_if.ready);
        pending_map_results.push_back(predict_map_step(c, int'(px), int'(py)));
    endtask

    task automatic wait_drained();
        items_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_map_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_if.ready);
        if (idx == REG_IMAGE_WIDTH)
        begin
            width_reg = value;
        end
        else
        begin
            height_reg = value;
        end
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (pending_map_results.size() == 0)
            begin
                $error("unexpected result transfer: distance %0d, count %0d, status %0d",
                       results_if.distance, results_if.obstacle_count, results_if.status);
                mismatch_count++;
            end
            else
            begin
                oldest_result = pending_map_results.pop_front();
                if (results_if.distance !== oldest_result.distance)
                begin
                    $error("distance mismatch: expected %0d, actual %0d",
                           oldest_result.distance, results_if.distance);
                    mismatch_count++;
                end
                if (results_if.obstacle_count !== oldest_result.obstacle_count)
                begin
                    $error("obstacle_count mismatch: expected %0d, actual %0d",
                           oldest_result.obstacle_count, results_if.obstacle_count);
                    mismatch_count++;
                end
                if (results_if.status !== oldest_result.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           oldest_result.status, results_if.status);
                    mismatch_count++;
                end
            end
        end
        results_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic test_reset_map();
        send_item(CMD_QUERY, 9'd0, 9'd0);
        send_item(CMD_UNUSED, 9'd511, 9'd511);
    endtask

    task automatic test_oversized_strip();
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, 10'd1023);
        write_reg(REG_IMAGE_HEIGHT, 10'd4);
        send_item(CMD_ADD, 9'd511, 9'd3);
        send_item(CMD_QUERY, 9'd0, 9'd0);
        send_item(CMD_ADD, 9'd0, 9'd0);
        send_item(CMD_QUERY, 9'd300, 9'd2);
        send_item(CMD_ADD, 9'd511, 9'd0);
    endtask

    task automatic test_outside_points();
        send_item(CMD_ADD, 9'd5, 9'd4);
        send_item(CMD_QUERY, 9'd0, 9'd511);
        send_item(CMD_UNUSED, 9'd511, 9'd511);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, 10'd0);
        send_item(CMD_QUERY, 9'd0, 9'd0);
        send_item(CMD_ADD, 9'd0, 9'd0);
    endtask

    task automatic test_tall_column();
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, 10'd1);
        write_reg(REG_IMAGE_HEIGHT, 10'd1023);
        send_item(CMD_ADD, 9'd0, 9'd511);
        send_item(CMD_QUERY, 9'd0, 9'd0);
        send_item(CMD_QUERY, 9'd1, 9'd0);
    endtask

    task automatic test_clear_map();
        wait_drained();
        write_reg(REG_IMAGE_HEIGHT, 10'd1);
        send_item(CMD_ADD, 9'd0, 9'd0);
        send_item(CMD_CLEAR, 9'd511, 9'd511);
        send_item(CMD_QUERY, 9'd0, 9'd0);
    endtask

    task automatic test_random_maps(input int count, input int send_pct, input int recv_pct);
        int               sent;
        int               batch;
        int               w_use;
        int               h_use;
        int               pick;
        logic [CMD_W-1:0] c;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [CFG_W-1:0]   new_w;
        logic [CFG_W-1:0]   new_h;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:
                begin
                    new_w = CFG_W'($urandom_range(512, 1023));
                    new_h = CFG_W'($urandom_range(1, 3));
                end
                1:
                begin
                    new_w = CFG_W'($urandom_range(1, 3));
                    new_h = CFG_W'($urandom_range(512, 1023));
                end
                2:
                begin
                    new_w = CFG_W'($urandom_range(0, 1023));
                    new_h = CFG_W'($urandom_range(0, 1023));
                end
                default:
                begin
                    new_w = CFG_W'($urandom_range(1, 24));
                    new_h = CFG_W'($urandom_range(1, 24));
                end
            endcase
            wait_drained();
            write_reg(REG_IMAGE_WIDTH, new_w);
            write_reg(REG_IMAGE_HEIGHT, new_h);
            w_use = width_in_use();
            h_use = height_in_use();
            batch = $urandom_range(12, 30);
            if (batch > count - sent)
            begin
                batch = count - sent;
            end
            repeat (batch)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    wait_drained();
                end
                if (w_use == 0 || h_use == 0 || $urandom_range(0, 4) == 0)
                begin
                    px = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
                    py = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
                end
                else
                begin
                    px = COORD_W'($urandom_range(0, w_use - 1));
                    py = COORD_W'($urandom_range(0, h_use - 1));
                end
                pick = $urandom_range(0, 9);
                c = (pick < 5) ? CMD_ADD : (pick < 9) ? CMD_QUERY : CMD_UNUSED;
                // A first obstacle in a large image walks the whole map, so adds stay small.
                if (c == CMD_ADD && w_use * h_use > ADD_AREA_LIMIT)
                begin
                    c = CMD_QUERY;
                end
                send_item(c, px, py);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        items_if.valid   = 1'b0;
        items_if.cmd     = CMD_QUERY;
        items_if.x       = '0;
        items_if.y       = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = REG_IMAGE_WIDTH;
        cfg_if.data      = '0;
        width_reg        = WIDTH_RESET;
        height_reg       = HEIGHT_RESET;
        clear_map();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_map();
        test_oversized_strip();
        test_outside_points();
        test_tall_column();
        test_clear_map();
        test_random_maps(91, 14, 78);
        test_random_maps(91, 78, 14);
        test_random_maps(90, 0, 0);

        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
